@@ rtl/stsc_pkg.sv @@
// Package for the source text scanner: word types, codes and byte constants.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package stsc_pkg;

  // Input word.
  typedef struct packed {
    logic       req_type;
    logic [7:0] byte_value;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic        kind;
    logic [23:0] new_line_ofs;
    logic [23:0] total_lines;
    logic [23:0] total_bytes;
    logic [23:0] char_count;
    logic [23:0] max_line_len;
    logic [1:0]  encoding;
    logic        utf8_valid;
    logic        last;
  } out_word_t;

  // Up to two result words pushed into the output queue in one cycle.
  typedef struct packed {
    logic [1:0] n;
    out_word_t  r0;
    out_word_t  r1;
  } push_t;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_END  = 1'b1;

  localparam logic KIND_LINE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [1:0] ENC_ASCII    = 2'd0;
  localparam logic [1:0] ENC_UTF8     = 2'd1;
  localparam logic [1:0] ENC_UTF8_BOM = 2'd2;

  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BOM_0   = 8'hEF;
  localparam logic [7:0] BOM_1   = 8'hBB;
  localparam logic [7:0] BOM_2   = 8'hBF;

  localparam logic [7:0] MASK_2B = 8'hE0;
  localparam logic [7:0] LEAD_2B = 8'hC0;
  localparam logic [7:0] MASK_3B = 8'hF0;
  localparam logic [7:0] LEAD_3B = 8'hE0;
  localparam logic [7:0] MASK_4B = 8'hF8;
  localparam logic [7:0] LEAD_4B = 8'hF0;
  localparam logic [7:0] MASK_CONT = 8'hC0;
  localparam logic [7:0] PAT_CONT  = 8'h80;

  localparam logic [1:0] BOM_NONE = 2'd0;
  localparam logic [1:0] BOM_ONE  = 2'd1;
  localparam logic [1:0] BOM_TWO  = 2'd2;
  localparam logic [1:0] BOM_FULL = 2'd3;

  localparam int unsigned Q_DEPTH    = 4;
  localparam int unsigned Q_PTR_BITS = 2;
  localparam int unsigned Q_CNT_BITS = 3;

  // Number of continuation bytes that follow a lead byte.
  function automatic logic [1:0] lead_len(input logic [7:0] b);
    logic [1:0] len;
    len = 2'd0;
    if ((b & MASK_2B) == LEAD_2B) len = 2'd1;
    else if ((b & MASK_3B) == LEAD_3B) len = 2'd2;
    else if ((b & MASK_4B) == LEAD_4B) len = 2'd3;
    return len;
  endfunction

  // True for ASCII and for the three multibyte lead patterns.
  function automatic logic lead_ok(input logic [7:0] b);
    return (b[7] == 1'b0) || ((b & MASK_2B) == LEAD_2B) ||
           ((b & MASK_3B) == LEAD_3B) || ((b & MASK_4B) == LEAD_4B);
  endfunction

endpackage

`default_nettype wire

@@ rtl/stsc_out_queue.sv @@
// Four-entry result queue that takes up to two words per cycle and gives one while out_stall is low.
// Depends on stsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stsc_out_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire stsc_pkg::push_t push,
  output logic                room,
  output logic                out_valid,
  input  wire                 out_stall,
  output stsc_pkg::out_word_t out_data
);
  import stsc_pkg::*;

  out_word_t             mem_r [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_BITS-1:0] count_r, count_nxt;
  logic                  pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // Two free entries are needed since an end word can push two results.
  assign room      = (count_r <= Q_CNT_BITS'(Q_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_PTR_BITS'(push.n);
    rd_ptr_nxt = rd_ptr_r + Q_PTR_BITS'(pop);
    count_nxt  = count_r + Q_CNT_BITS'(push.n) - Q_CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_r + Q_PTR_BITS'(1)] <= push.r1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (Q_CNT_BITS + 1)'(count_r) + (Q_CNT_BITS + 1)'(push.n) <= (Q_CNT_BITS + 1)'(Q_DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> $past(room) || !$past(rst_n) || (count_r <= Q_CNT_BITS'(Q_DEPTH - 2)))
    else $error("push into a queue without room");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

@@ rtl/stsc_scan_core.sv @@
// Per-byte scanner state: line break tracking, character statistics,
// UTF-8 check and encoding detection. Depends on stsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stsc_scan_core #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                accept,
  input  wire stsc_pkg::in_word_t in_word,
  output stsc_pkg::push_t    push
);
  import stsc_pkg::*;

  localparam int unsigned W  = COUNT_BITS;
  localparam int unsigned MW = (W > 24) ? W : 24;

  logic [W-1:0] off_r, off_nxt;
  logic         lcr_r, lcr_nxt;
  logic         scr_r, scr_nxt;
  logic [1:0]   skip_r, skip_nxt;
  logic [1:0]   ce_r, ce_nxt;
  logic         vld_r, vld_nxt;
  logic [W-1:0] lt_r, lt_nxt;
  logic [W-1:0] ct_r, ct_nxt;
  logic [W-1:0] cur_r, cur_nxt;
  logic [W-1:0] lng_r, lng_nxt;
  logic         hi_r, hi_nxt;
  logic [1:0]   bom_r, bom_nxt;

  logic [7:0]   b;
  logic         is_lf, is_cr;
  logic         emit;
  logic [W-1:0] emit_at;
  logic [W-1:0] longest;
  logic [W-1:0] lt_end;
  logic [1:0]   enc;
  out_word_t    sum_word;

  function automatic logic [W-1:0] sat_inc(input logic [W-1:0] v);
    return (v == '1) ? v : v + W'(1);
  endfunction

  function automatic logic [23:0] clamp24(input logic [W-1:0] v);
    logic [MW-1:0] ext;
    ext = MW'(v);
    return (ext > MW'(24'hFFFFFF)) ? 24'hFFFFFF : ext[23:0];
  endfunction

  function automatic out_word_t line_word(input logic [W-1:0] start);
    out_word_t w;
    w              = '0;
    w.kind         = KIND_LINE;
    w.new_line_ofs = clamp24(start);
    return w;
  endfunction

  assign b     = in_word.byte_value;
  assign is_lf = (b == BYTE_LF);
  assign is_cr = (b == BYTE_CR);

  // Summary fields, valid when the end word is taken.
  always_comb begin
    longest = (cur_r > lng_r) ? cur_r : lng_r;
    lt_end  = lcr_r ? sat_inc(lt_r) : lt_r;
    if (bom_r == BOM_FULL) enc = ENC_UTF8_BOM;
    else if (hi_r) enc = ENC_UTF8;
    else enc = ENC_ASCII;
    sum_word              = '0;
    sum_word.kind         = KIND_SUMMARY;
    sum_word.total_lines  = clamp24(lt_end);
    sum_word.total_bytes  = clamp24(off_r);
    sum_word.char_count   = clamp24(ct_r);
    sum_word.max_line_len = clamp24(longest);
    sum_word.encoding     = enc;
    sum_word.utf8_valid   = vld_r && (ce_r == 2'd0);
    sum_word.last         = 1'b1;
  end

  always_comb begin
    off_nxt  = off_r;
    lcr_nxt  = lcr_r;
    scr_nxt  = scr_r;
    skip_nxt = skip_r;
    ce_nxt   = ce_r;
    vld_nxt  = vld_r;
    lt_nxt   = lt_r;
    ct_nxt   = ct_r;
    cur_nxt  = cur_r;
    lng_nxt  = lng_r;
    hi_nxt   = hi_r;
    bom_nxt  = bom_r;
    emit     = 1'b0;
    emit_at  = off_r;
    push     = '0;

    if (accept && (in_word.req_type == REQ_END)) begin
      if (lcr_r) begin
        push.n  = 2'd2;
        push.r0 = line_word(off_r);
        push.r1 = sum_word;
      end else begin
        push.n  = 2'd1;
        push.r0 = sum_word;
      end
      // The summary closes the text; the next byte starts a new one.
      off_nxt  = '0;
      lcr_nxt  = 1'b0;
      scr_nxt  = 1'b0;
      skip_nxt = 2'd0;
      ce_nxt   = 2'd0;
      vld_nxt  = 1'b1;
      lt_nxt   = W'(1);
      ct_nxt   = '0;
      cur_nxt  = '0;
      lng_nxt  = '0;
      hi_nxt   = 1'b0;
      bom_nxt  = BOM_NONE;
    end else if (accept) begin
      if (b[7]) hi_nxt = 1'b1;
      if (off_r == '0 && bom_r == BOM_NONE && b == BOM_0) bom_nxt = BOM_ONE;
      else if (off_r == W'(1) && bom_r == BOM_ONE && b == BOM_1) bom_nxt = BOM_TWO;
      else if (off_r == W'(2) && bom_r == BOM_TWO && b == BOM_2) bom_nxt = BOM_FULL;
      off_nxt = sat_inc(off_r);

      // Line starts. A CR waits one byte to see whether an LF joins it.
      if (lcr_r) begin
        emit    = 1'b1;
        emit_at = is_lf ? off_nxt : off_r;
        lcr_nxt = is_cr;
      end else if (is_lf) begin
        emit    = 1'b1;
        emit_at = off_nxt;
      end else if (is_cr) begin
        lcr_nxt = 1'b1;
      end
      if (emit) begin
        lt_nxt  = sat_inc(lt_r);
        push.n  = 2'd1;
        push.r0 = line_word(emit_at);
      end

      // Character statistics; bytes skipped after a lead are not examined.
      if (skip_r != 2'd0) begin
        skip_nxt = skip_r - 2'd1;
      end else if (scr_r && is_lf) begin
        scr_nxt = 1'b0;
      end else begin
        scr_nxt = 1'b0;
        if (is_lf || is_cr) begin
          lng_nxt = longest;
          cur_nxt = '0;
          scr_nxt = is_cr;
        end else begin
          cur_nxt  = sat_inc(cur_r);
          skip_nxt = lead_len(b);
        end
        ct_nxt = sat_inc(ct_r);
      end

      // Validity check on lead and continuation patterns.
      if (ce_r != 2'd0) begin
        if ((b & MASK_CONT) == PAT_CONT) begin
          ce_nxt = ce_r - 2'd1;
        end else begin
          vld_nxt = 1'b0;
          ce_nxt  = 2'd0;
        end
      end else if (!lead_ok(b)) begin
        vld_nxt = 1'b0;
      end else begin
        ce_nxt = lead_len(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= '0;
      lcr_r  <= 1'b0;
      scr_r  <= 1'b0;
      skip_r <= 2'd0;
      ce_r   <= 2'd0;
      vld_r  <= 1'b1;
      lt_r   <= W'(1);
      ct_r   <= '0;
      cur_r  <= '0;
      lng_r  <= '0;
      hi_r   <= 1'b0;
      bom_r  <= BOM_NONE;
    end else begin
      off_r  <= off_nxt;
      lcr_r  <= lcr_nxt;
      scr_r  <= scr_nxt;
      skip_r <= skip_nxt;
      ce_r   <= ce_nxt;
      vld_r  <= vld_nxt;
      lt_r   <= lt_nxt;
      ct_r   <= ct_nxt;
      cur_r  <= cur_nxt;
      lng_r  <= lng_nxt;
      hi_r   <= hi_nxt;
      bom_r  <= bom_nxt;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_word.req_type == REQ_END) |=> (off_r == '0) && (lt_r == W'(1)) && !lcr_r)
    else $error("state not cleared after summary");

  a_line_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    lt_r != '0)
    else $error("line total dropped to zero");

  a_end_pushes_summary: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_word.req_type == REQ_END) |-> (push.n != 2'd0) &&
      ((push.n == 2'd1 && push.r0.last) || (push.n == 2'd2 && push.r1.last)))
    else $error("end word without summary");

  a_lines_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    lt_r <= sat_inc(off_r))
    else $error("more lines than bytes allow");

endmodule

`default_nettype wire

@@ rtl/source_text_scanner_unit.sv @@
// Top level of the source text scanner: scanner core and result queue.
// Depends on stsc_pkg, stsc_scan_core and stsc_out_queue.
//
//   channel  direction  handshake            word
//   in_      input      in_valid / in_stall  stsc_pkg::in_word_t
//   out_     output     out_valid / out_stall stsc_pkg::out_word_t
//
// One input word is taken per cycle while in_stall is low; its results enter the
// result queue at the same edge and reach out_ after the results queued before them.
// An end word yields up to two results, so in_stall rises whenever the queue
// holds fewer than two free entries; with out_stall low it never rises.
// rst_n is synchronous and active low; it empties the queue and clears state.
`timescale 1ns / 1ps
`default_nettype none

module source_text_scanner_unit #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire stsc_pkg::in_word_t in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output stsc_pkg::out_word_t out_data
);
  import stsc_pkg::*;

  push_t push;
  logic  room;
  logic  accept;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  stsc_scan_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .in_word(in_data),
    .push   (push)
  );

  stsc_out_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
